>>> sv/block_rms_peak_level_meter_unit_macros.svh
// ---------------------------------------------------------------------------
// Level meter assertion macros
// Concurrent check helpers clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BLOCK_RMS_PEAK_LEVEL_METER_UNIT_MACROS_SVH
`define BLOCK_RMS_PEAK_LEVEL_METER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define LMU_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("level meter check failed");
// Check that a condition never occurs out of reset
`define LMU_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("level meter forbidden condition seen");
`else
`define LMU_ASSERT(name, prop)
`define LMU_NEVER(name, cond)
`endif

`endif

>>> sv/lmu_pkg.sv
// ---------------------------------------------------------------------------
// Level meter package
// Widths, register codes and the request types of the root unit.
// ---------------------------------------------------------------------------
package lmu_pkg;

  // Field and datapath widths
  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 16;
  localparam int COEF_BITS     = 16;
  localparam int LEVEL_BITS    = 16;
  localparam int ACC_BITS      = 48;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Divide / square root unit widths
  localparam int DIVISOR_BITS = COUNT_BITS + 1;
  localparam int ROOT_BITS    = ACC_BITS / 2;
  localparam int ALU_BITS     = ROOT_BITS + 3;
  localparam int STEP_BITS    = $clog2(ACC_BITS);

  // Level ceiling and reset block size
  localparam logic [LEVEL_BITS-1:0]    LEVEL_MAX      = LEVEL_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [CFG_DATA_BITS-1:0] BLOCK_SIZE_RST = CFG_DATA_BITS'(480);

  // Mode codes
  localparam logic MODE_RMS  = 1'b0;
  localparam logic MODE_PEAK = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODE       = 2'd0,
    REG_BLOCK_SIZE = 2'd1,
    REG_ATTACK     = 2'd2,
    REG_DECAY      = 2'd3
  } cfg_reg_e;

  // Request into the root unit
  typedef struct packed {
    logic                    start;
    logic [ACC_BITS-1:0]     dividend;
    logic [DIVISOR_BITS-1:0] divisor;
  } root_req_t;

  // Status out of the root unit
  typedef struct packed {
    logic busy;
    logic done;
  } root_sts_t;

endpackage

>>> sv/lmu_if.sv
// ---------------------------------------------------------------------------
// Level meter channels
// Valid/ready channels for samples, levels and register writes.
// ---------------------------------------------------------------------------
interface lmu_sample_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [lmu_pkg::SAMPLE_BITS-1:0]    sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lmu_level_if;
  logic                              valid;
  logic                              ready;
  logic [lmu_pkg::LEVEL_BITS-1:0]    level;
  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface lmu_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lmu_pkg::CFG_IDX_BITS-1:0]     index;
  logic [lmu_pkg::CFG_DATA_BITS-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/lmu_root.sv
// ---------------------------------------------------------------------------
// Level meter root unit
// Restoring divide of the block sum by the sample count, then a digit-by-digit
// integer square root of the quotient, both on one shared subtractor.
// ---------------------------------------------------------------------------
module lmu_root (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lmu_pkg::root_req_t                  req_i,
  output lmu_pkg::root_sts_t                  sts_o,
  output logic [lmu_pkg::ROOT_BITS-1:0]       root_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e                               state_q, state_d;
  logic [lmu_pkg::STEP_BITS-1:0]        step_q, step_d;
  logic [lmu_pkg::DIVISOR_BITS-1:0]     divisor_q, divisor_d;
  logic [lmu_pkg::ACC_BITS-1:0]         quo_q, quo_d;
  logic [lmu_pkg::ALU_BITS-1:0]         rem_q, rem_d;
  logic [lmu_pkg::ROOT_BITS-1:0]        root_q, root_d;

  logic [lmu_pkg::ALU_BITS-1:0]         op_a, op_b, rem_next;
  logic [lmu_pkg::ALU_BITS:0]           diff;
  logic                                 ge;

  // Select the operands of the shared subtractor
  always_comb begin
    if (state_q == ST_DIV) begin
      op_a = lmu_pkg::ALU_BITS'({rem_q[lmu_pkg::DIVISOR_BITS-1:0],
                                  quo_q[lmu_pkg::ACC_BITS-1]});
      op_b = lmu_pkg::ALU_BITS'(divisor_q);
    end else begin
      op_a = {rem_q[lmu_pkg::ALU_BITS-3:0], quo_q[lmu_pkg::ACC_BITS-1 -: 2]};
      op_b = lmu_pkg::ALU_BITS'({root_q, 2'b01});
    end
  end

  // Trial subtract; keep the difference when it does not borrow
  assign diff     = {1'b0, op_a} - {1'b0, op_b};
  assign ge       = ~diff[lmu_pkg::ALU_BITS];
  assign rem_next = ge ? diff[lmu_pkg::ALU_BITS-1:0] : op_a;

  // Sequence the divide steps, then the root steps
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    divisor_d = divisor_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    root_d    = root_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          quo_d     = req_i.dividend;
          divisor_d = req_i.divisor;
          rem_d     = '0;
          step_d    = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = rem_next;
        quo_d  = {quo_q[lmu_pkg::ACC_BITS-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == lmu_pkg::STEP_BITS'(lmu_pkg::ACC_BITS - 1)) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rem_d  = rem_next;
        root_d = {root_q[lmu_pkg::ROOT_BITS-2:0], ge};
        quo_d  = {quo_q[lmu_pkg::ACC_BITS-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == lmu_pkg::STEP_BITS'(lmu_pkg::ROOT_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Hold the working operands
  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
  end

  assign sts_o.busy = (state_q == ST_DIV) || (state_q == ST_SQRT);
  assign sts_o.done = (state_q == ST_DONE);
  assign root_o     = root_q;

endmodule

>>> sv/block_rms_peak_level_meter_unit.sv
// ---------------------------------------------------------------------------
// Block RMS / peak level meter
// Gathers samples into blocks, forms the block RMS or peak and smooths it
// into a level with separate attack and decay weights.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  carries signed samples; out_o carries one smoothed level per
//   finished block; cfg_i writes mode, block_size, attack_coeff and
//   decay_coeff (index 0..3) and is always ready. Write registers only while
//   the meter is idle.
//   A sample that does not end a block passes through accept, square and
//   accumulate; in_i.ready is low meanwhile.
//   A block end in peak mode goes on from accumulate through multiply and update.
//   A block end in RMS mode also waits on the root unit before that: its
//   subtractor runs 48 divide steps, 24 square root steps and a finishing state.
//   The level sits in an output register, so the next samples are taken
//   while it waits; only the next level stalls until out_o takes the last.
//   Reset clears the count, the sum and the level, sets block_size to 480,
//   mode to RMS and both weights to zero.
// ---------------------------------------------------------------------------
`include "block_rms_peak_level_meter_unit_macros.svh"

module block_rms_peak_level_meter_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  lmu_cfg_if.sink       cfg_i,
  lmu_sample_if.sink    in_i,
  lmu_level_if.source   out_o
);

  localparam int PROD_BITS = lmu_pkg::LEVEL_BITS + lmu_pkg::COEF_BITS;
  localparam logic [PROD_BITS:0] HALF = (PROD_BITS + 1)'(1) << (lmu_pkg::COEF_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_MULT,
    ST_UPDATE
  } state_e;

  // Configuration registers
  logic                                mode_q;
  logic [lmu_pkg::CFG_DATA_BITS-1:0]   bsize_q;
  logic [lmu_pkg::COEF_BITS-1:0]       attack_q;
  logic [lmu_pkg::COEF_BITS-1:0]       decay_q;

  // Control and state
  state_e                              state_q, state_d;
  logic [lmu_pkg::COUNT_BITS-1:0]      count_q, count_d;
  logic [lmu_pkg::ACC_BITS-1:0]        acc_q, acc_d;
  logic [lmu_pkg::LEVEL_BITS-1:0]      smooth_q, smooth_d;
  logic [lmu_pkg::LEVEL_BITS-1:0]      level_q, level_d;
  logic                                out_valid_q, out_valid_d;

  // Datapath registers
  logic [lmu_pkg::SAMPLE_BITS-1:0]     sample_q, sample_d;
  logic [lmu_pkg::SAMPLE_BITS-1:0]     mag_q, mag_d;
  logic [2*lmu_pkg::SAMPLE_BITS-1:0]   sq_q, sq_d;
  logic [lmu_pkg::LEVEL_BITS-1:0]      value_q, value_d;
  logic                                fall_q, fall_d;
  logic [PROD_BITS-1:0]                prod_q, prod_d;

  // Combinational helpers
  logic [lmu_pkg::SAMPLE_BITS-1:0]     mag;
  logic [lmu_pkg::ACC_BITS-1:0]        acc_next;
  logic [lmu_pkg::COUNT_BITS-1:0]      count_next;
  logic [lmu_pkg::CFG_DATA_BITS-1:0]   bsize_eff;
  logic                                block_end;
  logic                                fall;
  logic [lmu_pkg::LEVEL_BITS-1:0]      diff;
  logic [lmu_pkg::COEF_BITS-1:0]       coeff;
  logic [PROD_BITS:0]                  rounded;
  logic [lmu_pkg::LEVEL_BITS:0]        step_t;
  logic [lmu_pkg::LEVEL_BITS:0]        new_level;
  logic                                load_out;

  lmu_pkg::root_req_t                  root_req;
  lmu_pkg::root_sts_t                  root_sts;
  logic [lmu_pkg::ROOT_BITS-1:0]       root;

  // Clamp a block value to the level ceiling
  function automatic logic [lmu_pkg::LEVEL_BITS-1:0] sat_level(
    input logic [lmu_pkg::ACC_BITS-1:0] v
  );
    if (v > lmu_pkg::ACC_BITS'(lmu_pkg::LEVEL_MAX)) begin
      return lmu_pkg::LEVEL_MAX;
    end
    return v[lmu_pkg::LEVEL_BITS-1:0];
  endfunction

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lmu_pkg::MODE_RMS;
      bsize_q  <= lmu_pkg::BLOCK_SIZE_RST;
      attack_q <= '0;
      decay_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (lmu_pkg::cfg_reg_e'(cfg_i.index))
        lmu_pkg::REG_MODE:       mode_q   <= cfg_i.data[0];
        lmu_pkg::REG_BLOCK_SIZE: bsize_q  <= cfg_i.data;
        lmu_pkg::REG_ATTACK:     attack_q <= cfg_i.data[lmu_pkg::COEF_BITS-1:0];
        lmu_pkg::REG_DECAY:      decay_q  <= cfg_i.data[lmu_pkg::COEF_BITS-1:0];
        default:                 mode_q   <= mode_q;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Take the magnitude of the held sample
  assign mag = sample_q[lmu_pkg::SAMPLE_BITS-1] ? (~sample_q + 1'b1) : sample_q;

  // Add the square, or keep the larger magnitude
  assign acc_next = (mode_q == lmu_pkg::MODE_RMS)
                  ? (acc_q + lmu_pkg::ACC_BITS'(sq_q))
                  : ((lmu_pkg::ACC_BITS'(mag_q) > acc_q) ? lmu_pkg::ACC_BITS'(mag_q) : acc_q);

  // Detect the end of a block; a zero block size acts as one
  assign count_next = count_q + 1'b1;
  assign bsize_eff  = (bsize_q == '0) ? lmu_pkg::CFG_DATA_BITS'(1) : bsize_q;
  assign block_end  = (count_next == '0) || (32'(count_next) >= 32'(bsize_eff));

  // Request the mean square root at the end of an RMS block
  assign root_req.start    = (state_q == ST_ACCUM) && block_end && (mode_q == lmu_pkg::MODE_RMS);
  assign root_req.dividend = acc_next;
  assign root_req.divisor  = (count_next == '0)
                           ? {1'b1, {lmu_pkg::COUNT_BITS{1'b0}}}
                           : {1'b0, count_next};

  lmu_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .sts_o  (root_sts),
    .root_o (root)
  );

  // Pick the weight and distance toward the old level
  assign fall  = value_q < smooth_q;
  assign diff  = fall ? (smooth_q - value_q) : (value_q - smooth_q);
  assign coeff = fall ? decay_q : attack_q;

  // Round the weighted step half up and move from the block value
  assign rounded   = {1'b0, prod_q} + HALF;
  assign step_t    = rounded[PROD_BITS:lmu_pkg::COEF_BITS];
  assign new_level = fall_q ? ({1'b0, value_q} + step_t) : ({1'b0, value_q} - step_t);
  assign load_out  = (state_q == ST_UPDATE) && (!out_valid_q || out_o.ready);

  // Sequence each sample through square and accumulate, and a block end through root (RMS only) and smoothing
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    acc_d       = acc_q;
    smooth_d    = smooth_q;
    level_d     = level_q;
    out_valid_d = out_valid_q && !out_o.ready;
    sample_d    = sample_q;
    mag_d       = mag_q;
    sq_d        = sq_q;
    value_d     = value_q;
    fall_d      = fall_q;
    prod_d      = prod_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          sample_d = in_i.sample;
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        mag_d   = mag;
        sq_d    = {{lmu_pkg::SAMPLE_BITS{1'b0}}, mag} * {{lmu_pkg::SAMPLE_BITS{1'b0}}, mag};
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (block_end) begin
          count_d = '0;
          acc_d   = '0;
          if (mode_q == lmu_pkg::MODE_RMS) begin
            state_d = ST_ROOT;
          end else begin
            value_d = sat_level(acc_next);
            state_d = ST_MULT;
          end
        end else begin
          count_d = count_next;
          acc_d   = acc_next;
          state_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (root_sts.done) begin
          value_d = sat_level(lmu_pkg::ACC_BITS'(root));
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        fall_d  = fall;
        prod_d  = {{lmu_pkg::LEVEL_BITS{1'b0}}, coeff} * {{lmu_pkg::COEF_BITS{1'b0}}, diff};
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (load_out) begin
          smooth_d    = new_level[lmu_pkg::LEVEL_BITS-1:0];
          level_d     = new_level[lmu_pkg::LEVEL_BITS-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      acc_q       <= '0;
      smooth_q    <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      acc_q       <= acc_d;
      smooth_q    <= smooth_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold datapath operands
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    mag_q    <= mag_d;
    sq_q     <= sq_d;
    value_q  <= value_d;
    fall_q   <= fall_d;
    prod_q   <= prod_d;
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.level = level_q;

  // Root unit is working or finishing while the sequencer waits on it
  `LMU_ASSERT(a_root_wait, (state_q == ST_ROOT) |-> (root_sts.busy || root_sts.done))
  // A root request only reaches an idle unit
  `LMU_ASSERT(a_root_start_idle, root_req.start |-> !(root_sts.busy || root_sts.done))
  // A loaded level is offered in the next cycle
  `LMU_ASSERT(a_load_valid, load_out |=> out_valid_q)
  // The offered level never exceeds the ceiling
  `LMU_NEVER(a_level_range, out_valid_q && (level_q > lmu_pkg::LEVEL_MAX))

endmodule
